### design/adaptive_peak_picker_assert.svh
// Assertion macros shared by the peak picker checker
`ifndef ADAPTIVE_PEAK_PICKER_ASSERT_SVH
`define ADAPTIVE_PEAK_PICKER_ASSERT_SVH

// clocked assertion, off while in reset
`define APP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("adaptive_peak_picker assertion failed");

// clocked assertion, also checked across reset
`define APP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("adaptive_peak_picker reset assertion failed");

`endif

### design/app_pkg.sv
// Package: sizes, state encoding and register indexes for the peak picker
package app_pkg;

  localparam int MAX_HISTORY   = 64;
  localparam int MAX_LOOKAHEAD = 16;
  localparam int RING_DEPTH    = 128;
  localparam int PEND_DEPTH    = 32;
  localparam int MAX_RESULTS   = MAX_LOOKAHEAD + 1;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int PEND_AW = $clog2(PEND_DEPTH);
  localparam int HIST_W  = 7;
  localparam int LA_W    = 5;
  localparam int CNT_W   = $clog2(MAX_HISTORY + 1);
  localparam int MAG_W   = 31 + $clog2(MAX_HISTORY) + 1;
  localparam int SUM_W   = MAG_W + 1;
  localparam int DIV_CW  = $clog2(MAG_W + 1);
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int LVL_W   = 33;
  localparam int PEND_W  = LVL_W + 2;

  localparam logic [2:0] REG_MAX_HIST  = 3'd0;
  localparam logic [2:0] REG_MEAN_HIST = 3'd1;
  localparam logic [2:0] REG_OFFSET    = 3'd2;
  localparam logic [2:0] REG_SPACING   = 3'd3;
  localparam logic [2:0] REG_LOOKAHEAD = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_LEVEL,
    ST_DEC_CHK,
    ST_DV_RD,
    ST_DV_WT,
    ST_SC_RD,
    ST_SC_CMP,
    ST_OUT,
    ST_DONE
  } state_t;

endpackage

### design/adaptive_peak_picker.sv
// Top level: adaptive-threshold peak picker over a Q16.16 envelope stream
//
// Input channel in_valid/in_ready carries sample, allowed and final_frame.
// Output channel out_valid/out_ready carries one decision per frame.
// Config channel cfg_valid/cfg_ready writes registers 0..4 by cfg_index.
// Each item writes its sample into a 128-entry ring, then sums up to
// mean_window_history earlier samples, floor-divides the sum by the
// count in a radix-2 divider and stores the level. Each decision then
// reads the frame and scans its window
// [d - max_window_history, d + lookahead] one sample at a time.
// Results leave through a one-entry output register; while the receiver
// stalls the block waits before writing the next result into it.
// in_ready is high only between items. A final_frame item flushes every
// pending frame, then clears the sequence state. Synchronous reset
// returns the registers to their defaults; ring contents are not cleared.
module adaptive_peak_picker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    sample,
  input  logic                  allowed,
  input  logic                  final_frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           frame_number,
  output logic                  peak_found,
  output logic signed [31:0]    level,
  output logic                  level_valid,
  output logic                  run_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import app_pkg::*;

  state_t state, state_next;

  logic [HIST_W-1:0] max_hist, mean_hist;
  logic [30:0]       offset;
  logic [15:0]       spacing;
  logic [LA_W-1:0]   look;

  logic signed [31:0] ring_mem [RING_DEPTH];
  logic [PEND_W-1:0]  pend_mem [PEND_DEPTH];
  logic [RING_AW-1:0] raddr;
  logic signed [31:0] rdata;
  logic [PEND_W-1:0]  pdata;

  logic [31:0] frames_seen, nd, last_peak, f, d, last, fr;
  logic        any_peak, fin, alw;
  logic [RES_W-1:0] n_res;
  logic [CNT_W-1:0] k, cnt;
  logic signed [SUM_W-1:0] sum;
  logic [MAG_W-1:0] dvd, quo;
  logic [CNT_W-1:0] rem;
  logic [DIV_CW-1:0] dcnt;
  logic neg;
  logic signed [31:0] v;
  logic signed [LVL_W-1:0] lv;
  logic lvalid, lalw, ismax;

  // effective settings
  logic [HIST_W-1:0] h_eff, m_eff;
  logic [LA_W-1:0]   la;
  logic [15:0]       sp_eff;
  assign h_eff  = (max_hist == '0) ? HIST_W'(1) :
                  (max_hist > HIST_W'(MAX_HISTORY)) ? HIST_W'(MAX_HISTORY) : max_hist;
  assign m_eff  = (mean_hist == '0) ? HIST_W'(1) :
                  (mean_hist > HIST_W'(MAX_HISTORY)) ? HIST_W'(MAX_HISTORY) : mean_hist;
  assign la     = (look > LA_W'(MAX_LOOKAHEAD)) ? LA_W'(MAX_LOOKAHEAD) : look;
  assign sp_eff = (spacing == '0) ? 16'd1 : spacing;

  logic in_acc, out_free;
  assign in_ready  = (state == ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // decide-loop checks
  logic [31:0] gap, back;
  logic more, stop_la;
  assign gap     = f - nd;
  assign more    = (nd != frames_seen) && (n_res < RES_W'(MAX_RESULTS));
  assign stop_la = !fin && (gap < 32'(la));
  assign back    = (nd > 32'(h_eff)) ? 32'(h_eff) : nd;

  logic cont, peak, spaced;
  logic [31:0] d1;
  assign d1     = d + 32'd1;
  assign cont   = (d1 != frames_seen) && ((n_res + RES_W'(1)) < RES_W'(MAX_RESULTS)) &&
                  (fin || ((f - d1) >= 32'(la)));
  assign spaced = !any_peak || ((d - last_peak) >= 32'(sp_eff));
  assign peak   = ismax && lvalid && (LVL_W'(v) >= lv) && lalw && spaced;

  // divider step and level
  logic [CNT_W:0] rem_sh;
  logic           qbit;
  logic signed [LVL_W-1:0] qs, qv, lvl_new;
  assign rem_sh  = {rem, dvd[MAG_W-1]};
  assign qbit    = rem_sh >= {1'b0, cnt};
  assign qs      = $signed({1'b0, quo[31:0]});
  assign qv      = neg ? (-qs - LVL_W'(rem != '0)) : qs;
  assign lvl_new = qv + $signed({2'b0, offset});

  logic signed [31:0] sat;
  assign sat = !lvalid ? 32'sd0 :
               (lv > LVL_W'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF :
               (lv < -LVL_W'(33'sh0_8000_0000)) ? 32'sh8000_0000 : lv[31:0];

  always_comb begin
    state_next = state;
    raddr      = fr[RING_AW-1:0];
    case (state)
      ST_IDLE:     if (in_acc) state_next = (frames_seen == '0) ? ST_LEVEL : ST_SUM_RD;
      ST_SUM_RD: begin
        raddr      = RING_AW'(f - 32'(k));
        state_next = ST_SUM_ACC;
      end
      ST_SUM_ACC:  state_next = (k == cnt) ? ST_DIV_INIT : ST_SUM_RD;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      if (dcnt == DIV_CW'(MAG_W - 1)) state_next = ST_LEVEL;
      ST_LEVEL:    state_next = ST_DEC_CHK;
      ST_DEC_CHK:  state_next = (more && !stop_la) ? ST_DV_RD : ST_DONE;
      ST_DV_RD: begin
        raddr      = d[RING_AW-1:0];
        state_next = ST_DV_WT;
      end
      ST_DV_WT:    state_next = ST_SC_RD;
      ST_SC_RD:    state_next = ST_SC_CMP;
      ST_SC_CMP:   state_next = (fr == last) ? ST_OUT : ST_SC_RD;
      ST_OUT:      if (out_free) state_next = ST_DEC_CHK;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc) ring_mem[frames_seen[RING_AW-1:0]] <= sample;
    rdata <= ring_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_LEVEL)
      pend_mem[f[PEND_AW-1:0]] <= {alw, (f != '0), (f != '0) ? lvl_new : LVL_W'(0)};
    pdata <= pend_mem[d[PEND_AW-1:0]];
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_hist  <= HIST_W'(3);
      mean_hist <= HIST_W'(8);
      offset    <= '0;
      spacing   <= 16'd1;
      look      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_HIST:  max_hist  <= cfg_data[HIST_W-1:0];
        REG_MEAN_HIST: mean_hist <= cfg_data[HIST_W-1:0];
        REG_OFFSET:    offset    <= cfg_data[30:0];
        REG_SPACING:   spacing   <= cfg_data[15:0];
        REG_LOOKAHEAD: look      <= cfg_data[LA_W-1:0];
        default: ;
      endcase
    end
  end

  // sequence control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen <= '0;
      nd          <= '0;
      last_peak   <= '0;
      any_peak    <= 1'b0;
      n_res       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready)               out_valid <= 1'b0;
      case (state)
        ST_IDLE:  n_res <= '0;
        ST_LEVEL: frames_seen <= f + 32'd1;
        ST_OUT: begin
          if (out_free) begin
            nd        <= d1;
            n_res     <= n_res + RES_W'(1);
            if (peak) begin
              last_peak <= d;
              any_peak  <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (fin) begin
            frames_seen <= '0;
            nd          <= '0;
            last_peak   <= '0;
            any_peak    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          f   <= frames_seen;
          fin <= final_frame;
          alw <= allowed;
          k   <= CNT_W'(1);
          sum <= '0;
          cnt <= (frames_seen > 32'(m_eff)) ? CNT_W'(m_eff) : CNT_W'(frames_seen);
        end
      end
      ST_SUM_ACC: begin
        sum <= sum + SUM_W'(rdata);
        k   <= k + CNT_W'(1);
      end
      ST_DIV_INIT: begin
        neg  <= sum < 0;
        dvd  <= (sum < 0) ? MAG_W'(-sum) : MAG_W'(sum);
        rem  <= '0;
        quo  <= '0;
        dcnt <= '0;
      end
      ST_DIV: begin
        rem  <= qbit ? CNT_W'(rem_sh - {1'b0, cnt}) : CNT_W'(rem_sh);
        quo  <= {quo[MAG_W-2:0], qbit};
        dvd  <= {dvd[MAG_W-2:0], 1'b0};
        dcnt <= dcnt + DIV_CW'(1);
      end
      ST_DEC_CHK: begin
        d    <= nd;
        last <= (gap < 32'(la)) ? f : nd + 32'(la);
        fr   <= nd - back;
      end
      ST_DV_WT: begin
        v      <= rdata;
        lv     <= $signed(pdata[LVL_W-1:0]);
        lvalid <= pdata[LVL_W];
        lalw   <= pdata[LVL_W+1];
        ismax  <= 1'b1;
      end
      ST_SC_CMP: begin
        if (rdata > v) ismax <= 1'b0;
        fr <= fr + 32'd1;
      end
      ST_OUT: begin
        if (out_free) begin
          frame_number <= d;
          peak_found   <= peak;
          level        <= sat;
          level_valid  <= lvalid;
          run_end      <= !cont;
        end
      end
      default: ;
    endcase
  end

endmodule

### design/app_checker.sv
// Port-level checker for the peak picker, bound to the top level
`include "adaptive_peak_picker_assert.svh"

module app_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] frame_number,
  input logic signed [31:0] level,
  input logic        level_valid,
  input logic        run_end
);

  `APP_ASSERT_RST(a_reset_empty, rst |=> !out_valid)
  `APP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(frame_number))
  `APP_ASSERT(a_busy_mid_run, out_valid && !run_end |-> !in_ready)
  `APP_ASSERT(a_no_level_zero, out_valid && !level_valid |-> level == 32'sd0)

endmodule

bind adaptive_peak_picker app_checker u_app_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_number (frame_number),
  .level        (level),
  .level_valid  (level_valid),
  .run_end      (run_end)
);

### tb/tb_top.sv
// Self-checking testbench for adaptive_peak_picker: directed, random and stall tests
`timescale 1ns / 100ps

module tb_top;
  import app_pkg::*;

  typedef struct packed {
    logic [31:0]        frame;
    logic               peak;
    logic signed [31:0] lvl;
    logic               lvl_ok;
    logic               last;
  } decision_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] sample = '0;
  logic allowed = 1'b0;
  logic final_frame = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] frame_number;
  logic peak_found;
  logic signed [31:0] level;
  logic level_valid;
  logic run_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  adaptive_peak_picker dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] env_ring [RING_DEPTH];
  logic               elig_ring [PEND_DEPTH];
  longint             thr_ring [PEND_DEPTH];
  logic               thr_ok_ring [PEND_DEPTH];
  logic [31:0] seq_frames, next_frame, prev_peak;
  logic        had_peak;
  logic [6:0]  reg_max_hist, reg_mean_hist;
  logic [30:0] reg_offset;
  logic [15:0] reg_spacing;
  logic [4:0]  reg_lookahead;

  decision_t pending_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_peaks = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int hold_off = 0;

  function automatic logic [31:0] hist_eff(logic [6:0] r);
    if (r == 0) return 1;
    if (r > MAX_HISTORY) return MAX_HISTORY;
    return r;
  endfunction

  function automatic void clear_seq();
    seq_frames = 0;
    next_frame = 0;
    prev_peak = 0;
    had_peak = 1'b0;
  endfunction

  function automatic void decide_frame(logic [31:0] d, logic [31:0] last_fr, bit tail);
    logic [31:0] h, back, lo, fr, spc;
    logic signed [31:0] v;
    bit is_max, pk;
    longint sat;
    decision_t e;
    h = hist_eff(reg_max_hist);
    back = (d > h) ? h : d;
    lo = d - back;
    v = env_ring[d % RING_DEPTH];
    is_max = 1'b1;
    for (int k = 0; k <= back + MAX_LOOKAHEAD; k++) begin
      fr = lo + k;
      if (env_ring[fr % RING_DEPTH] > v) is_max = 1'b0;
      if (fr == last_fr) break;
    end
    spc = (reg_spacing == 0) ? 1 : reg_spacing;
    pk = is_max && thr_ok_ring[d % PEND_DEPTH] && (longint'(v) >= thr_ring[d % PEND_DEPTH])
         && elig_ring[d % PEND_DEPTH] && (!had_peak || (d - prev_peak) >= spc);
    if (pk) begin
      prev_peak = d;
      had_peak = 1'b1;
    end
    sat = 0;
    if (thr_ok_ring[d % PEND_DEPTH]) begin
      sat = thr_ring[d % PEND_DEPTH];
      if (sat > 64'sh7fffffff) sat = 64'sh7fffffff;
      if (sat < -64'sh80000000) sat = -64'sh80000000;
    end
    e.frame = d;
    e.peak = pk;
    e.lvl = sat[31:0];
    e.lvl_ok = thr_ok_ring[d % PEND_DEPTH];
    e.last = tail;
    pending_q.insert(pending_q.size(), e);
  endfunction

  function automatic void predict_item(logic signed [31:0] s, logic a, logic fin);
    logic [31:0] f, m, cnt, la, gap, last_fr;
    longint acc, q;
    int n;
    f = seq_frames;
    env_ring[f % RING_DEPTH] = s;
    elig_ring[f % PEND_DEPTH] = a;
    thr_ring[f % PEND_DEPTH] = 0;
    thr_ok_ring[f % PEND_DEPTH] = 1'b0;
    if (f != 0) begin
      m = hist_eff(reg_mean_hist);
      cnt = (f > m) ? m : f;
      acc = 0;
      for (int k = 1; k <= cnt; k++) acc += longint'(env_ring[(f - k) % RING_DEPTH]);
      q = acc / longint'(cnt);
      if ((acc % longint'(cnt)) != 0 && acc < 0) q -= 1;
      thr_ring[f % PEND_DEPTH] = q + longint'(reg_offset);
      thr_ok_ring[f % PEND_DEPTH] = 1'b1;
    end
    seq_frames = f + 1;
    la = (reg_lookahead > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD : reg_lookahead;
    n = 0;
    while (next_frame != seq_frames && n < MAX_RESULTS) begin
      gap = f - next_frame;
      if (!fin && gap < la) break;
      last_fr = (gap < la) ? f : next_frame + la;
      decide_frame(next_frame, last_fr, 1'b0);
      next_frame++;
      n++;
    end
    if (n > 0) pending_q[$].last = 1'b1;
    if (fin) clear_seq();
  endfunction

  // receiver: random stalls, optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    decision_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result frame=%0d", $time, frame_number);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (peak_found) n_peaks++;
        if (frame_number !== e.frame) begin
          $display("%0t: frame_number exp %0d act %0d", $time, e.frame, frame_number);
          errors++;
        end
        if (peak_found !== e.peak) begin
          $display("%0t: peak_found frame %0d exp %0b act %0b", $time, e.frame, e.peak,
                   peak_found);
          errors++;
        end
        if (level !== e.lvl) begin
          $display("%0t: level frame %0d exp %0d act %0d", $time, e.frame, e.lvl, level);
          errors++;
        end
        if (level_valid !== e.lvl_ok) begin
          $display("%0t: level_valid frame %0d exp %0b act %0b", $time, e.frame, e.lvl_ok,
                   level_valid);
          errors++;
        end
        if (run_end !== e.last) begin
          $display("%0t: run_end frame %0d exp %0b act %0b", $time, e.frame, e.last, run_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 20000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(logic signed [31:0] s, logic a, logic fin);
    if (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    allowed <= a;
    final_frame <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(s, a, fin);
    n_items++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain outputs, then allow an in-flight item with no result to finish
  task automatic wait_quiet();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAX_HIST:  reg_max_hist = val[6:0];
      REG_MEAN_HIST: reg_mean_hist = val[6:0];
      REG_OFFSET:    reg_offset = val[30:0];
      REG_SPACING:   reg_spacing = val[15:0];
      REG_LOOKAHEAD: reg_lookahead = val[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic setup(int mh, int wh, logic [31:0] off, int spc, int la);
    wait_quiet();
    write_reg(REG_MAX_HIST, mh);
    write_reg(REG_MEAN_HIST, wh);
    write_reg(REG_OFFSET, off);
    write_reg(REG_SPACING, spc);
    write_reg(REG_LOOKAHEAD, la);
  endtask

  function automatic logic signed [31:0] rand_env();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return -$signed({16'd0, 16'(($urandom()))});
      default: return $signed(32'($urandom_range(200000)));
    endcase
  endfunction

  task automatic test_directed();
    setup(3, 8, 0, 1, 0);
    send_item(32'sh00010000, 1'b1, 1'b0);
    send_item(32'sh7fffffff, 1'b1, 1'b0);
    send_item(32'sh80000000, 1'b1, 1'b0);
    send_item(32'sh00020000, 1'b0, 1'b0);
    send_item(-32'sd3, 1'b1, 1'b1);
    // negative samples, zero history and spacing registers act as one
    setup(0, 0, 0, 0, 0);
    send_item(-32'sd7, 1'b1, 1'b0);
    send_item(-32'sd2, 1'b1, 1'b0);
    send_item(-32'sd1, 1'b1, 1'b0);
    send_item(-32'sd1, 1'b1, 1'b1);
    // saturated level, out-of-range history and lookahead
    setup(127, 127, 32'hffffffff, 65535, 31);
    for (int i = 0; i < 5; i++) send_item(32'sh7fffff00 + i, 1'b1, 1'b0);
    send_item(32'sh7fffffff, 1'b1, 1'b1);
    // lookahead lowered mid-sequence decides several frames at once
    setup(64, 64, 32'h7fffffff, 1, 16);
    write_reg(REG_OFFSET, 0);
    for (int i = 0; i < 6; i++) send_item(i * 100, 1'b1, 1'b0);
    wait_quiet();
    write_reg(REG_LOOKAHEAD, 1);
    send_item(50, 1'b1, 1'b0);
    send_item(600, 1'b1, 1'b1);
  endtask

  task automatic random_run(int count);
    int left;
    left = count;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 40);
      for (int i = 0; i < len && left > 0; i++) begin
        left--;
        send_item(rand_env(), $urandom_range(99) < 80, (i == len - 1) || left == 0);
      end
    end
  endtask

  task automatic test_random();
    setup(3, 8, 0, 1, 0);
    random_run(70);
    setup(1, 1, 32'h00008000, 2, 2);
    random_run(70);
    setup(64, 64, $urandom(), 65535, 16);
    random_run(60);
    setup($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(0, 65536),
          $urandom_range(1, 6), $urandom_range(0, 8));
    random_run(70);
    setup($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_run(60);
  endtask

  task automatic test_stall();
    setup(5, 4, 0, 3, 4);
    hold_off = 3000;
    random_run(30);
    wait_quiet();
    calm = 1'b1;
    random_run(40);
    calm = 1'b0;
    wait_quiet();
    random_run(20);
  endtask

  initial begin
    reg_max_hist = 3;
    reg_mean_hist = 8;
    reg_offset = 0;
    reg_spacing = 1;
    reg_lookahead = 0;
    clear_seq();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_stall();
    wait_quiet();
    if (pending_q.size() != 0) begin
      $display("%0d expected results never arrived", pending_q.size());
      errors++;
    end
    $display("sent %0d items, checked %0d decisions (%0d peaks) in %0d cycles",
             n_items, n_results, n_peaks, cycles);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
